// ===== design/fpc_pkg.sv =====
package fpc_pkg;

  localparam logic [15:0] END_LIMIT       = 16'hFFF6;
  localparam int          DIR_ENTRY_BYTES = 32;

  localparam logic [2:0] REG_PART_FIRST  = 3'd0;
  localparam logic [2:0] REG_RESERVED    = 3'd1;
  localparam logic [2:0] REG_FAT_COPIES  = 3'd2;
  localparam logic [2:0] REG_FAT_SECTORS = 3'd3;
  localparam logic [2:0] REG_ROOT_ENTS   = 3'd4;
  localparam logic [2:0] REG_CLUS_SECS   = 3'd5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SKIP_TEST,
    ST_SKIP_CHK,
    ST_ZERO_OK,
    ST_ZERO_BAD,
    ST_PIECE,
    ST_LINK,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic fat_wr;
    logic load;
    logic div_init;
    logic div_step;
    logic skip_init;
    logic take_skip;
    logic take_link;
    logic mul;
    logic emit_piece;
    logic emit_zero;
    logic zero_status;
  } cmd_t;

  typedef struct packed {
    logic pos_ge_size;
    logic div_done;
    logic skip_zero;
    logic rd_bad;
    logic cap_zero;
    logic need_link;
    logic piece_fin;
    logic out_free;
  } sts_t;

endpackage

// ===== design/fat16_cluster_chain_read_planner.sv =====
// FAT16 cluster-chain read planner.
// Input stream (s_*): s_tuser selects the request kind. A load request writes
// one FAT entry and gives no result. A read request walks the chain past
// every whole cluster before read_position, then emits one result per sector
// to fetch on the output stream (m_*), with m_tlast on the final one and
// m_tuser flagging a chain that ended while skipping.
// Steps of a read request after acceptance: check the offset, run the
// cluster-skip divider, test the skip count and read the FAT once per skipped
// cluster, then for each sector piece compute its sector and emit it, with a
// FAT link read first when the piece crosses into a new cluster. The single
// FAT read port sets the chain-walking pace.
// The user writes configuration registers via cfg_we/cfg_index/cfg_data only
// while no request is in progress (not enforced). Reset clears the controller
// and output valid and restores register defaults; FAT contents are undefined
// until loaded. A stalled receiver holds the current result; the block waits
// before producing the next piece and takes no new request until the last
// result of the current one has been placed in the output register.
module fat16_cluster_chain_read_planner #(
  parameter int FAT_ENTRIES  = 65536,
  parameter int SECTOR_BYTES = 512,
  parameter int MAX_PIECES   = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // fat_index, fat_value, start_cluster, file_bytes, read_position, capacity
  input  logic [127:0] s_tdata,
  // opcode
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // sector_number, skip_bytes, copy_bytes, position_after, bytes_so_far
  output logic [103:0] m_tdata,
  // status
  output logic [0:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import fpc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [31:0] part_first;
  logic [15:0] reserved;
  logic [2:0]  fat_copies;
  logic [8:0]  fat_sectors;
  logic [15:0] root_entries;
  logic [7:0]  clus_secs;

  logic [31:0] sector_number;
  logic [8:0]  skip_bytes;
  logic [9:0]  copy_bytes;
  logic [31:0] position_after;
  logic [14:0] bytes_so_far;

  always_ff @(posedge clk) begin
    if (rst) begin
      part_first   <= 32'd0;
      reserved     <= 16'd1;
      fat_copies   <= 3'd2;
      fat_sectors  <= 9'd1;
      root_entries <= 16'd512;
      clus_secs    <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PART_FIRST:  part_first   <= cfg_data;
        REG_RESERVED:    reserved     <= cfg_data[15:0];
        REG_FAT_COPIES:  fat_copies   <= cfg_data[2:0];
        REG_FAT_SECTORS: fat_sectors  <= cfg_data[8:0];
        REG_ROOT_ENTS:   root_entries <= cfg_data[15:0];
        REG_CLUS_SECS:   clus_secs    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  fpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_opcode (s_tuser[0]),
    .in_ready  (s_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpc_dp #(
    .FAT_ENTRIES  (FAT_ENTRIES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .MAX_PIECES   (MAX_PIECES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .fat_index        (s_tdata[15:0]),
    .fat_value        (s_tdata[31:16]),
    .start_cluster    (s_tdata[47:32]),
    .file_bytes       (s_tdata[79:48]),
    .read_position    (s_tdata[111:80]),
    .capacity         (s_tdata[126:112]),
    .cfg_part_first   (part_first),
    .cfg_reserved     (reserved),
    .cfg_fat_copies   (fat_copies),
    .cfg_fat_sectors  (fat_sectors),
    .cfg_root_entries (root_entries),
    .cfg_clus_secs    (clus_secs),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .sector_number    (sector_number),
    .skip_bytes       (skip_bytes),
    .copy_bytes       (copy_bytes),
    .position_after   (position_after),
    .bytes_so_far     (bytes_so_far),
    .status           (m_tuser[0]),
    .last             (m_tlast)
  );

  assign m_tdata = {6'd0, bytes_so_far, position_after, copy_bytes, skip_bytes,
                    sector_number};

endmodule

// ===== design/fpc_ctrl.sv =====
module fpc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_opcode,
  output logic          in_ready,
  input  fpc_pkg::sts_t sts,
  output fpc_pkg::cmd_t cmd
);
  import fpc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_opcode == OP_READ) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = sts.pos_ge_size ? ST_ZERO_OK : ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_next = ST_SKIP_TEST;
      end
      ST_SKIP_TEST: begin
        if (!sts.skip_zero) state_next = ST_SKIP_CHK;
        else if (sts.cap_zero) state_next = ST_ZERO_OK;
        else state_next = ST_PIECE;
      end
      ST_SKIP_CHK: begin
        state_next = sts.rd_bad ? ST_ZERO_BAD : ST_SKIP_TEST;
      end
      ST_ZERO_OK, ST_ZERO_BAD: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      ST_PIECE: begin
        state_next = sts.need_link ? ST_LINK : ST_MUL;
      end
      ST_LINK: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_next = sts.piece_fin ? ST_IDLE : ST_PIECE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.fat_wr = in_valid && in_opcode == OP_LOAD;
        cmd.load   = in_valid && in_opcode == OP_READ;
      end
      ST_CHECK: begin
        cmd.div_init = !sts.pos_ge_size;
      end
      ST_DIV: begin
        cmd.div_step  = !sts.div_done;
        cmd.skip_init = sts.div_done;
      end
      ST_SKIP_CHK: begin
        cmd.take_skip = !sts.rd_bad;
      end
      ST_ZERO_OK: begin
        cmd.emit_zero = sts.out_free;
      end
      ST_ZERO_BAD: begin
        cmd.emit_zero   = sts.out_free;
        cmd.zero_status = 1'b1;
      end
      ST_LINK: begin
        cmd.take_link = 1'b1;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_piece = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/fpc_dp.sv =====
module fpc_dp #(
  parameter int FAT_ENTRIES  = 65536,
  parameter int SECTOR_BYTES = 512,
  parameter int MAX_PIECES   = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  fpc_pkg::cmd_t cmd,
  output fpc_pkg::sts_t sts,
  input  logic [15:0]   fat_index,
  input  logic [15:0]   fat_value,
  input  logic [15:0]   start_cluster,
  input  logic [31:0]   file_bytes,
  input  logic [31:0]   read_position,
  input  logic [14:0]   capacity,
  input  logic [31:0]   cfg_part_first,
  input  logic [15:0]   cfg_reserved,
  input  logic [2:0]    cfg_fat_copies,
  input  logic [8:0]    cfg_fat_sectors,
  input  logic [15:0]   cfg_root_entries,
  input  logic [7:0]    cfg_clus_secs,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   sector_number,
  output logic [8:0]    skip_bytes,
  output logic [9:0]    copy_bytes,
  output logic [31:0]   position_after,
  output logic [14:0]   bytes_so_far,
  output logic          status,
  output logic          last
);
  import fpc_pkg::*;

  localparam int LOG_SB = $clog2(SECTOR_BYTES);
  localparam int AW     = $clog2(FAT_ENTRIES);
  localparam int QW     = 32 - LOG_SB;
  localparam int DCW    = $clog2(QW + 1);
  localparam int NW     = $clog2(MAX_PIECES + 1);
  localparam int CW     = LOG_SB + 1;

  logic [15:0] mem [FAT_ENTRIES];
  logic [15:0] mem_q;
  logic        mem_oor;

  logic [15:0]     cluster;
  logic [31:0]     pos;
  logic [31:0]     size;
  logic [14:0]     cap;
  logic [14:0]     total;
  logic [NW-1:0]   n;
  logic [7:0]      sic;
  logic [LOG_SB-1:0] skipb;
  logic [QW-1:0]   dq;
  logic [7:0]      rem;
  logic [DCW-1:0]  dcnt;
  logic [31:0]     data_start;
  logic [31:0]     prod;

  logic [7:0]      csec;
  logic [21:0]     root_sum;
  logic [31:0]     ds_calc;
  logic [15:0]     lookup;
  logic [8:0]      rem_sh;
  logic [31:0]     avail;
  logic [CW-1:0]   room;
  logic [CW-1:0]   c1;
  logic [CW-1:0]   copy;
  logic [31:0]     pos_new;
  logic [14:0]     cap_new;
  logic [LOG_SB:0] skip_sum;
  logic [8:0]      sic_inc;

  assign csec     = (cfg_clus_secs == 8'd0) ? 8'd1 : cfg_clus_secs;
  assign root_sum = ({6'd0, cfg_root_entries} << $clog2(DIR_ENTRY_BYTES))
                    + 22'(SECTOR_BYTES - 1);
  assign ds_calc  = cfg_part_first + {16'd0, cfg_reserved}
                    + (32'(cfg_fat_copies) * 32'(cfg_fat_sectors))
                    + {10'd0, root_sum >> LOG_SB};

  // chain lookups beyond the table read as end of chain
  always_ff @(posedge clk) begin
    if (cmd.fat_wr && {1'b0, fat_index} < 17'(FAT_ENTRIES)) begin
      mem[fat_index[AW-1:0]] <= fat_value;
    end
    mem_q   <= mem[cluster[AW-1:0]];
    mem_oor <= {1'b0, cluster} >= 17'(FAT_ENTRIES);
  end

  assign lookup = mem_oor ? 16'hFFFF : mem_q;
  assign rem_sh = {rem, dq[QW-1]};

  assign avail    = size - pos;
  assign room     = CW'(SECTOR_BYTES) - {1'b0, skipb};
  assign c1       = (avail < 32'(room)) ? avail[CW-1:0] : room;
  assign copy     = (32'(cap) < 32'(c1)) ? CW'(cap) : c1;
  assign pos_new  = pos + 32'(copy);
  assign cap_new  = cap - 15'(copy);
  assign skip_sum = {1'b0, skipb} + (LOG_SB + 1)'(copy);
  assign sic_inc  = {1'b0, sic} + 9'd1;

  assign sts.pos_ge_size = pos >= size;
  assign sts.div_done    = dcnt == '0;
  assign sts.skip_zero   = dq == '0;
  assign sts.rd_bad      = lookup > END_LIMIT;
  assign sts.cap_zero    = cap == '0;
  assign sts.need_link   = n != '0 && sic == 8'd0 && skipb == '0;
  assign sts.piece_fin   = cap_new == '0 || pos_new >= size
                           || (NW + 1)'(n) + 1'b1 >= (NW + 1)'(MAX_PIECES);
  assign sts.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cluster    <= start_cluster;
      pos        <= read_position;
      size       <= file_bytes;
      cap        <= capacity;
      total      <= '0;
      n          <= '0;
      skipb      <= read_position[LOG_SB-1:0];
      data_start <= ds_calc;
    end
    if (cmd.div_init) begin
      dq   <= pos[31:LOG_SB];
      rem  <= '0;
      dcnt <= DCW'(QW);
    end
    if (cmd.div_step) begin
      dcnt <= dcnt - 1'b1;
      if (rem_sh >= {1'b0, csec}) begin
        rem <= 8'(rem_sh - {1'b0, csec});
        dq  <= {dq[QW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[7:0];
        dq  <= {dq[QW-2:0], 1'b0};
      end
    end
    if (cmd.skip_init) begin
      sic <= rem;
    end
    if (cmd.take_skip) begin
      cluster <= lookup;
      dq      <= dq - 1'b1;
    end
    if (cmd.take_link) begin
      cluster <= lookup;
    end
    if (cmd.mul) begin
      prod <= ({16'd0, cluster} - 32'd2) * {24'd0, csec};
    end
    if (cmd.emit_piece) begin
      pos   <= pos_new;
      cap   <= cap_new;
      total <= total + 15'(copy);
      n     <= n + 1'b1;
      skipb <= skip_sum[LOG_SB-1:0];
      if (skip_sum[LOG_SB]) begin
        sic <= (sic_inc == {1'b0, csec}) ? 8'd0 : sic_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_piece || cmd.emit_zero) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_zero) begin
      sector_number  <= '0;
      skip_bytes     <= '0;
      copy_bytes     <= '0;
      position_after <= pos;
      bytes_so_far   <= '0;
      status         <= cmd.zero_status;
      last           <= 1'b1;
    end else if (cmd.emit_piece) begin
      sector_number  <= data_start + prod + {24'd0, sic};
      skip_bytes     <= 9'(skipb);
      copy_bytes     <= 10'(copy);
      position_after <= pos_new;
      bytes_so_far   <= total + 15'(copy);
      status         <= 1'b0;
      last           <= sts.piece_fin;
    end
  end

endmodule
